/* rtl/core/tcw_pkg.sv */
// shared types, operation codes and cell helpers for the text console cell writer
`default_nettype none

package tcw_pkg;

    typedef logic [15:0] t_cell;
    typedef logic [2:0]  t_op;

    localparam t_op OP_PUT_CUR = 3'd0;
    localparam t_op OP_PUT_POS = 3'd1;
    localparam t_op OP_NEWLINE = 3'd2;
    localparam t_op OP_CLEAR   = 3'd3;
    localparam t_op OP_READ    = 3'd4;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'd15;

    // attribute in the high byte, character in the low byte
    function automatic t_cell make_cell(input logic [7:0] ch, input logic [7:0] attr);
        return {attr, ch};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/text_console_cell_writer.sv */
// Text console cell writer: a ROWS by COLS store of 16-bit cells (attribute in the high byte,
// character in the low byte) held in one synchronous RAM, plus a cursor. After reset the block
// sweeps the whole RAM to white-on-black spaces, one cell a cycle, and stalls its input
// meanwhile; colour writes are taken at any time. Character writes and positioned writes go
// to the single RAM write port at the transfer, and they and newlines that do not scroll load
// the result register directly; a cell read passes through the registered RAM read and the
// S_READ state first. A scroll walks the RAM with a read ahead of a write, one cell a cycle,
// then blanks the bottom row; a clear writes every cell once. Both load the result when done.
// The result sits in an output register, so a new item is taken in the same cycle as
// the previous result is transferred.
`default_nettype none

module text_console_cell_writer
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [2:0]  i_op,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [7:0]  i_cell_color,
    input  wire logic [6:0]  i_pos_col,
    input  wire logic [4:0]  i_pos_row,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [4:0]  o_cursor_row,
    output      logic [6:0]  o_cursor_col,
    output      logic [15:0] o_read_cell,
    output      logic        o_scrolled,
    output      logic        o_status
);

    localparam int TOTAL  = ROWS * COLS;
    localparam int COPY_N = (ROWS - 1) * COLS;
    localparam int AW     = $clog2(TOTAL);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_sweep, n_sweep;
    logic [4:0]    r_cur_row, n_cur_row;
    logic [6:0]    r_cur_col, n_cur_col;
    logic [7:0]    r_text_color;
    logic          r_out_valid, n_out_valid;
    logic [4:0]    r_o_row, n_o_row;
    logic [6:0]    r_o_col, n_o_col;
    t_cell         r_o_read, n_o_read;
    logic          r_o_scrolled, n_o_scrolled;
    logic          r_o_status, n_o_status;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_cell         ram_wdata, ram_rdata;

    logic          out_hold, accept, in_range, nl_wrap;
    logic [4:0]    nl_row;
    t_cell         blank;

    function automatic logic [AW-1:0] cell_addr(input logic [4:0] row, input logic [6:0] col);
        return AW'(row) * AW'(COLS) + AW'(col);
    endfunction

    tcw_screen_ram #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_hold   = r_out_valid && i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || out_hold;
    assign accept     = i_in_valid && !o_in_stall;
    assign in_range   = ({1'b0, i_pos_col} < 8'(COLS)) && ({1'b0, i_pos_row} < 6'(ROWS));
    assign nl_wrap    = r_cur_row >= 5'(ROWS - 1);
    assign nl_row     = nl_wrap ? 5'(ROWS - 1) : r_cur_row + 5'd1;
    assign blank      = make_cell(SPACE_CODE, r_text_color);

    always_comb begin
        logic do_nl;
        logic defer;
        logic st;
        do_nl        = 1'b0;
        defer        = 1'b0;
        st           = 1'b0;
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_cur_row    = r_cur_row;
        n_cur_col    = r_cur_col;
        n_out_valid  = out_hold;
        n_o_row      = r_o_row;
        n_o_col      = r_o_col;
        n_o_read     = r_o_read;
        n_o_scrolled = r_o_scrolled;
        n_o_status   = r_o_status;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = make_cell(SPACE_CODE, RESET_COLOR);
                if (r_sweep == AW'(TOTAL - 1)) begin
                    n_state = S_IDLE;
                    n_sweep = '0;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_PUT_CUR: begin
                            if (i_char_code == NEWLINE_CODE) begin
                                do_nl = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = cell_addr(r_cur_row, r_cur_col);
                                ram_wdata = make_cell(i_char_code, r_text_color);
                                if (r_cur_col == 7'(COLS - 1)) begin
                                    do_nl = 1'b1;
                                end else begin
                                    n_cur_col = r_cur_col + 7'd1;
                                end
                            end
                        end
                        OP_PUT_POS: begin
                            if (in_range) begin
                                ram_we    = 1'b1;
                                ram_waddr = cell_addr(i_pos_row, i_pos_col);
                                ram_wdata = make_cell(i_char_code, i_cell_color);
                            end else begin
                                st = 1'b1;
                            end
                        end
                        OP_NEWLINE: begin
                            do_nl = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_cur_row = '0;
                            n_cur_col = '0;
                            n_sweep   = '0;
                            n_state   = S_CLEAR;
                            defer     = 1'b1;
                        end
                        OP_READ: begin
                            if (in_range) begin
                                ram_re    = 1'b1;
                                ram_raddr = cell_addr(i_pos_row, i_pos_col);
                                n_state   = S_READ;
                                defer     = 1'b1;
                            end else begin
                                st = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (do_nl) begin
                        n_cur_col = '0;
                        n_cur_row = nl_row;
                        if (nl_wrap) begin
                            n_sweep = '0;
                            n_state = S_COPY;
                            defer   = 1'b1;
                        end
                    end
                    if (!defer) begin
                        n_out_valid  = 1'b1;
                        n_o_row      = n_cur_row;
                        n_o_col      = n_cur_col;
                        n_o_read     = '0;
                        n_o_scrolled = 1'b0;
                        n_o_status   = st;
                    end
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_o_row      = r_cur_row;
                n_o_col      = r_cur_col;
                n_o_read     = ram_rdata;
                n_o_scrolled = 1'b0;
                n_o_status   = 1'b0;
                n_state      = S_IDLE;
            end
            S_COPY: begin
                // read one row ahead, write back the word fetched in the previous cycle
                if (r_sweep != AW'(COPY_N)) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_sweep + AW'(COLS);
                end
                if (r_sweep != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_sweep - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (r_sweep == AW'(COPY_N)) begin
                    n_state = S_FILL;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            S_FILL, S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = blank;
                if (r_sweep == AW'(TOTAL - 1)) begin
                    n_sweep      = '0;
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_o_row      = r_cur_row;
                    n_o_col      = r_cur_col;
                    n_o_read     = '0;
                    n_o_scrolled = (r_state == S_FILL);
                    n_o_status   = 1'b0;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_sweep      <= '0;
            r_cur_row    <= '0;
            r_cur_col    <= '0;
            r_out_valid  <= 1'b0;
            r_text_color <= RESET_COLOR;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_text_color <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_row      <= n_o_row;
        r_o_col      <= n_o_col;
        r_o_read     <= n_o_read;
        r_o_scrolled <= n_o_scrolled;
        r_o_status   <= n_o_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_read_cell  = r_o_read;
    assign o_scrolled   = r_o_scrolled;
    assign o_status     = r_o_status;

    // cursor never leaves the screen
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_row < 5'(ROWS)) && ({1'b0, r_cur_col} < 8'(COLS)))
        else $error("cursor outside the screen");

    // the scroll copy never writes at or past the cell it is fetching
    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY && ram_we && ram_re) |-> (ram_waddr < ram_raddr))
        else $error("scroll copy overtook its read");

    // no result is pending while a long operation is still running
    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_COPY || r_state == S_FILL || r_state == S_CLEAR)
        |-> !r_out_valid)
        else $error("result register loaded during a multi-cycle operation");

    // a scroll always leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_scrolled) |-> (r_o_row == 5'(ROWS - 1) && r_o_col == '0))
        else $error("scroll reported with cursor off the bottom row start");

    // a put at the cursor that does not wrap steps the column by one
    a_put_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_PUT_CUR && i_char_code != NEWLINE_CODE
         && r_cur_col != 7'(COLS - 1))
        |=> (r_cur_col == $past(r_cur_col) + 7'd1))
        else $error("cursor column did not advance");

endmodule

`default_nettype wire

/* rtl/core/tcw_screen_ram.sv */
// screen cell store: one write port and one registered read port
`default_nettype none

module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_cell         i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output      t_cell         o_rdata
);

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
